// ----- rtl/core/msaf_pkg.sv -----
// Shared types, constants and the control program of the mirror symmetry axis finder.
package msaf_pkg;

	localparam int PIX_W      = 8;
	localparam int AXIS_W     = 8;
	localparam int SUM_W      = 25;
	localparam int BOX_W_BITS = 9;
	localparam int BOX_H_BITS = 9;
	localparam int STEP_BITS  = 10;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [BOX_H_BITS-1:0] RC_CAP = 9'd511;

	localparam logic [1:0] REG_BOX_WIDTH  = 2'd0;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STEP_LIMIT = 2'd2;

	localparam logic [BOX_W_BITS-1:0] BOX_WIDTH_RST  = 9'd256;
	localparam logic [BOX_H_BITS-1:0] BOX_HEIGHT_RST = 9'd256;
	localparam logic [STEP_BITS-1:0]  STEP_LIMIT_RST = 10'd160;

	typedef struct packed {
		logic [BOX_W_BITS-1:0] box_width;
		logic [BOX_H_BITS-1:0] box_height;
		logic [STEP_BITS-1:0]  step_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_CHK_EMIT,
		ST_EMIT,
		ST_IDLE,
		ST_CHK_ACC,
		ST_COL_RD,
		ST_DIFF,
		ST_DRAIN,
		ST_CHK_LAST
	} step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_ROW_INIT,
		OP_COL_RD,
		OP_DIFF,
		OP_DRAIN,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_SCAN_END,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_FIRE,
		CND_ACCUM,
		CND_DMORE,
		CND_XMORE,
		CND_IMORE,
		CND_LAST,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t next_t;
		step_t next_f;
	} ctl_t;

	typedef struct packed {
		logic fire;
		logic accum;
		logic dmore;
		logic xmore;
		logic imore;
		logic last;
		logic out_busy;
	} stat_t;

	function automatic ctl_t ucode_rom(step_t s);
		ctl_t c;
		case (s)
			ST_SCAN_INIT: c = '{op: OP_SCAN_INIT, cond: CND_ALWAYS,
				next_t: ST_SCAN, next_f: ST_SCAN};
			ST_SCAN:      c = '{op: OP_SCAN, cond: CND_IMORE,
				next_t: ST_SCAN, next_f: ST_SCAN_END};
			ST_SCAN_END:  c = '{op: OP_SCAN_END, cond: CND_ALWAYS,
				next_t: ST_CHK_EMIT, next_f: ST_CHK_EMIT};
			ST_CHK_EMIT:  c = '{op: OP_NONE, cond: CND_LAST,
				next_t: ST_EMIT, next_f: ST_IDLE};
			ST_EMIT:      c = '{op: OP_EMIT, cond: CND_OUT_BUSY,
				next_t: ST_EMIT, next_f: ST_IDLE};
			ST_IDLE:      c = '{op: OP_ACCEPT, cond: CND_FIRE,
				next_t: ST_CHK_ACC, next_f: ST_IDLE};
			ST_CHK_ACC:   c = '{op: OP_ROW_INIT, cond: CND_ACCUM,
				next_t: ST_COL_RD, next_f: ST_CHK_LAST};
			ST_COL_RD:    c = '{op: OP_COL_RD, cond: CND_ALWAYS,
				next_t: ST_DIFF, next_f: ST_DIFF};
			ST_DIFF:      c = '{op: OP_DIFF, cond: CND_DMORE,
				next_t: ST_DIFF, next_f: ST_DRAIN};
			ST_DRAIN:     c = '{op: OP_DRAIN, cond: CND_XMORE,
				next_t: ST_COL_RD, next_f: ST_CHK_LAST};
			ST_CHK_LAST:  c = '{op: OP_NONE, cond: CND_LAST,
				next_t: ST_SCAN_INIT, next_f: ST_IDLE};
			default:      c = '{op: OP_NONE, cond: CND_ALWAYS,
				next_t: ST_IDLE, next_f: ST_IDLE};
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/msaf_pix_if.sv -----
// Pixel input channel: valid, ready and one pixel item.
interface msaf_pix_if;
	logic                       valid;
	logic                       ready;
	logic [msaf_pkg::PIX_W-1:0] pixel_value;
	logic                       last_pixel;

	modport source (output valid, output pixel_value, output last_pixel, input ready);
	modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

// ----- rtl/core/msaf_res_if.sv -----
// Result output channel: valid, ready and one axis item.
interface msaf_res_if;
	logic                        valid;
	logic                        ready;
	logic [msaf_pkg::AXIS_W-1:0] axis_column;
	logic [msaf_pkg::SUM_W-1:0]  best_score;
	logic                        not_found;

	modport source (output valid, output axis_column, output best_score, output not_found,
		input ready);
	modport sink   (input valid, input axis_column, input best_score, input not_found,
		output ready);
endinterface

// ----- rtl/core/mirror_symmetry_axis_finder_top.sv -----
// Top level of the mirror symmetry axis finder: registers, sequencer and datapath.
//
//  channel   dir  handshake                 payload
//  pixels    in   valid / ready             pixel_value[7:0], last_pixel
//  result    out  valid / ready             axis_column[7:0], best_score[24:0], not_found
//  apb       in   psel, penable, pready     paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  A pixel that ends a counted row, with lim above zero, adds a pass over every column: a read,
//  one difference step per offset up to lim and a drain, lim = min(step_limit, MAX_STEP_LIMIT) - 1
//  clipped to width - 1. The last pixel adds a sweep over the column sums and the load.
//  After reset a sweep clears the sums; no pixel is taken meanwhile.
//  A result waits in the output register while pixels are taken; besides the processing of each
//  pixel, the input stalls when a second result is ready before the first has been taken.
module mirror_symmetry_axis_finder_top #(
	parameter int MAX_BOX_WIDTH  = 256,
	parameter int MAX_STEP_LIMIT = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msaf_pkg::APB_AW-1:0] paddr,
	input  logic [msaf_pkg::APB_DW-1:0] pwdata,
	output logic [msaf_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	msaf_pix_if.sink                    pixels,
	msaf_res_if.source                  result
);
	import msaf_pkg::*;

	cfg_t  cfg;
	op_t   op;
	stat_t stat;

	msaf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msaf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	msaf_datapath #(
		.MAX_BOX_WIDTH  (MAX_BOX_WIDTH),
		.MAX_STEP_LIMIT (MAX_STEP_LIMIT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.op     (op),
		.pixels (pixels),
		.result (result),
		.stat   (stat)
	);
endmodule

// ----- rtl/core/msaf_apb_regs.sv -----
// APB configuration registers of the mirror symmetry axis finder.
module msaf_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msaf_pkg::APB_AW-1:0]   paddr,
	input  logic [msaf_pkg::APB_DW-1:0]   pwdata,
	output logic [msaf_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output msaf_pkg::cfg_t                cfg
);
	import msaf_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_width  <= BOX_WIDTH_RST;
			cfg_q.box_height <= BOX_HEIGHT_RST;
			cfg_q.step_limit <= STEP_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BOX_WIDTH:  cfg_q.box_width  <= pwdata[BOX_W_BITS-1:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= pwdata[BOX_H_BITS-1:0];
				REG_STEP_LIMIT: cfg_q.step_limit <= pwdata[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BOX_WIDTH:  prdata = APB_DW'(cfg_q.box_width);
			REG_BOX_HEIGHT: prdata = APB_DW'(cfg_q.box_height);
			REG_STEP_LIMIT: prdata = APB_DW'(cfg_q.step_limit);
			default:        prdata = '0;
		endcase
	end
endmodule

// ----- rtl/core/msaf_sequencer.sv -----
// Step counter and control store of the mirror symmetry axis finder.
module msaf_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  msaf_pkg::stat_t stat,
	output msaf_pkg::op_t   op
);
	import msaf_pkg::*;

	step_t step_q;
	step_t step_d;
	ctl_t  ctl;
	logic  cond_ok;

	assign ctl = ucode_rom(step_q);
	assign op  = ctl.op;

	always_comb begin
		case (ctl.cond)
			CND_ALWAYS:   cond_ok = 1'b1;
			CND_FIRE:     cond_ok = stat.fire;
			CND_ACCUM:    cond_ok = stat.accum;
			CND_DMORE:    cond_ok = stat.dmore;
			CND_XMORE:    cond_ok = stat.xmore;
			CND_IMORE:    cond_ok = stat.imore;
			CND_LAST:     cond_ok = stat.last;
			CND_OUT_BUSY: cond_ok = stat.out_busy;
			default:      cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		step_d = cond_ok ? ctl.next_t : ctl.next_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_SCAN_INIT;
		end else begin
			step_q <= step_d;
		end
	end
endmodule

// ----- rtl/core/msaf_datapath.sv -----
// Row store, column sum memory, difference unit, scan and output register.
module msaf_datapath #(
	parameter int MAX_BOX_WIDTH  = 256,
	parameter int MAX_STEP_LIMIT = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msaf_pkg::cfg_t  cfg,
	input  msaf_pkg::op_t   op,
	msaf_pix_if.sink        pixels,
	msaf_res_if.source      result,
	output msaf_pkg::stat_t stat
);
	import msaf_pkg::*;

	localparam int XW  = $clog2(MAX_BOX_WIDTH);
	localparam int WW  = $clog2(MAX_BOX_WIDTH + 1);
	localparam int BW  = (WW > BOX_W_BITS) ? WW : BOX_W_BITS;
	localparam int SLW = $clog2(MAX_STEP_LIMIT + 1);
	localparam int SW  = (SLW > STEP_BITS) ? SLW : STEP_BITS;
	localparam int LW  = (SW > WW) ? SW : WW;

	logic [PIX_W-1:0] row_mem [MAX_BOX_WIDTH];
	logic [SUM_W-1:0] col_mem [MAX_BOX_WIDTH];

	logic [BW-1:0]    bw_ext;
	logic [WW-1:0]    eff_w;
	logic [SW-1:0]    sl_ext;
	logic [SW-1:0]    sl_c;
	logic [LW-1:0]    sl_m1;
	logic [LW-1:0]    w_m1;
	logic [XW-1:0]    lim;

	logic             fire;
	logic [WW-1:0]    cc1;
	logic             row_end;
	logic [WW-1:0]    filled;

	logic [XW-1:0]    cc_q;
	logic [BOX_H_BITS-1:0] rc_q;
	logic             last_q;
	logic             accum_q;
	logic [WW-1:0]    filled_q;
	logic [XW-1:0]    lim_q;
	logic [XW-1:0]    x_q;
	logic [XW-1:0]    d_q;
	logic             pend_s1;
	logic             out_valid_q;

	logic [XW-1:0]    a_pos;
	logic [XW:0]      b_sum;
	logic             a_ok;
	logic             b_ok;
	logic             a_ok_s1;
	logic             b_ok_s1;
	logic [PIX_W-1:0] a_rd_s1;
	logic [PIX_W-1:0] b_rd_s1;
	logic [PIX_W-1:0] a_px;
	logic [PIX_W-1:0] b_px;
	logic [PIX_W-1:0] diff;
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] acc_sat;
	logic [SUM_W-1:0] acc_q;

	logic             col_we;
	logic             col_re;
	logic [SUM_W-1:0] col_wd;
	logic [SUM_W-1:0] col_rd_s1;

	logic [XW-1:0]    idx_s1;
	logic             take;
	logic [XW-1:0]    best_q;
	logic [SUM_W-1:0] score_q;
	logic             load_out;

	logic [AXIS_W-1:0] axis_q;
	logic [SUM_W-1:0]  res_score_q;
	logic              nf_q;

	always_comb begin
		bw_ext = BW'(cfg.box_width);
		eff_w  = (bw_ext > BW'(MAX_BOX_WIDTH)) ? WW'(MAX_BOX_WIDTH) : WW'(bw_ext);
		sl_ext = SW'(cfg.step_limit);
		sl_c   = (sl_ext > SW'(MAX_STEP_LIMIT)) ? SW'(MAX_STEP_LIMIT) : sl_ext;
		sl_m1  = (sl_c == '0) ? '0 : LW'(sl_c) - LW'(1);
		w_m1   = LW'(eff_w) - LW'(1);
		lim    = XW'((sl_m1 > w_m1) ? w_m1 : sl_m1);
	end

	assign pixels.ready = (op == OP_ACCEPT);
	assign fire         = pixels.valid && pixels.ready;
	assign cc1          = WW'(cc_q) + WW'(1);
	assign row_end      = (cc1 >= eff_w) || pixels.last_pixel;
	assign filled       = (cc1 > eff_w) ? eff_w : cc1;

	assign a_pos = x_q - d_q;
	assign b_sum = (XW+1)'(x_q) + (XW+1)'(d_q);
	assign a_ok  = (d_q <= x_q) && (WW'(a_pos) < filled_q);
	assign b_ok  = b_sum < (XW+1)'(filled_q);

	assign a_px    = a_ok_s1 ? a_rd_s1 : '0;
	assign b_px    = b_ok_s1 ? b_rd_s1 : '0;
	assign diff    = (a_px > b_px) ? (a_px - b_px) : (b_px - a_px);
	assign sum_ext = {1'b0, acc_q} + (SUM_W+1)'(diff);
	assign acc_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign col_we = (op == OP_DRAIN) || (op == OP_SCAN);
	assign col_re = (op == OP_COL_RD) || (op == OP_SCAN);
	assign col_wd = (op == OP_DRAIN) ? acc_sat : '0;

	assign take = pend_s1 && (WW'(idx_s1) < eff_w) && ((idx_s1 == '0) || (col_rd_s1 < score_q));

	assign stat.fire     = fire;
	assign stat.accum    = accum_q;
	assign stat.dmore    = d_q < lim_q;
	assign stat.xmore    = (WW'(x_q) + WW'(1)) < eff_w;
	assign stat.imore    = x_q != XW'(MAX_BOX_WIDTH - 1);
	assign stat.last     = last_q;
	assign stat.out_busy = out_valid_q && !result.ready;

	assign load_out = (op == OP_EMIT) && !stat.out_busy;

	always_ff @(posedge clk) begin
		if (fire && (eff_w != '0)) begin
			row_mem[cc_q] <= pixels.pixel_value;
		end
		if (op == OP_DIFF) begin
			a_rd_s1 <= row_mem[a_pos];
			b_rd_s1 <= row_mem[b_sum[XW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[x_q] <= col_wd;
		end
		if (col_re) begin
			col_rd_s1 <= col_mem[x_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q        <= '0;
			rc_q        <= '0;
			last_q      <= 1'b0;
			accum_q     <= 1'b0;
			x_q         <= '0;
			d_q         <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_ACCEPT: begin
					if (fire) begin
						last_q  <= pixels.last_pixel;
						accum_q <= 1'b0;
						if (eff_w != '0) begin
							accum_q <= row_end && (rc_q < cfg.box_height) && (lim != '0);
							if (row_end) begin
								cc_q <= '0;
								if (rc_q != RC_CAP) begin
									rc_q <= rc_q + 1'b1;
								end
							end else begin
								cc_q <= cc_q + 1'b1;
							end
						end
						if (pixels.last_pixel) begin
							cc_q <= '0;
							rc_q <= '0;
						end
					end
				end
				OP_ROW_INIT: begin
					x_q <= '0;
				end
				OP_COL_RD: begin
					d_q     <= XW'(1);
					pend_s1 <= 1'b0;
				end
				OP_DIFF: begin
					pend_s1 <= 1'b1;
					d_q     <= d_q + 1'b1;
				end
				OP_DRAIN: begin
					pend_s1 <= 1'b0;
					x_q     <= x_q + 1'b1;
				end
				OP_SCAN_INIT: begin
					x_q     <= '0;
					pend_s1 <= 1'b0;
				end
				OP_SCAN: begin
					pend_s1 <= 1'b1;
					x_q     <= x_q + 1'b1;
				end
				OP_SCAN_END: begin
					pend_s1 <= 1'b0;
				end
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				if (fire) begin
					filled_q <= filled;
					lim_q    <= lim;
				end
			end
			OP_DIFF: begin
				a_ok_s1 <= a_ok;
				b_ok_s1 <= b_ok;
				acc_q   <= pend_s1 ? acc_sat : col_rd_s1;
			end
			OP_SCAN_INIT: begin
				best_q  <= '0;
				score_q <= '0;
			end
			OP_SCAN: begin
				idx_s1 <= x_q;
				if (take) begin
					best_q  <= idx_s1;
					score_q <= col_rd_s1;
				end
			end
			OP_SCAN_END: begin
				if (take) begin
					best_q  <= idx_s1;
					score_q <= col_rd_s1;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			axis_q      <= AXIS_W'(best_q);
			res_score_q <= score_q;
			nf_q        <= (eff_w == '0);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.axis_column = axis_q;
	assign result.best_score  = res_score_q;
	assign result.not_found   = nf_q;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the mirror symmetry axis finder: directed table, then random boxes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msaf_pkg::*;

	localparam int MAX_BW   = 256;
	localparam int MAX_STEP = 512;
	localparam int SUM_CAP  = (1 << SUM_W) - 1;

	typedef struct packed {
		logic [AXIS_W-1:0] axis;
		logic [SUM_W-1:0]  score;
		logic              nf;
	} axis_res_t;

	typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;
	typedef enum {BOX_WHOLE, BOX_SHORT_TAIL, BOX_EXTRA_ROWS} box_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [1:0]       idx;
		logic [31:0]      val;
		logic [PIX_W-1:0] pv;
		logic             lp;
		bit               typed;
		axis_res_t        exp;
	} plan_row_t;

	localparam axis_res_t AXIS_ZERO = '{8'd0, 25'd0, 1'b0};
	localparam axis_res_t AXIS_NONE = '{8'd0, 25'd0, 1'b1};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	msaf_pix_if pix_ch ();
	msaf_res_if res_ch ();

	mirror_symmetry_axis_finder_top #(
		.MAX_BOX_WIDTH (MAX_BW),
		.MAX_STEP_LIMIT(MAX_STEP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.pixels (pix_ch),
		.result (res_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [BOX_W_BITS-1:0] cfg_width  = BOX_WIDTH_RST;
	logic [BOX_H_BITS-1:0] cfg_height = BOX_HEIGHT_RST;
	logic [STEP_BITS-1:0]  cfg_step   = STEP_LIMIT_RST;
	logic [PIX_W-1:0]      line_pix [MAX_BW];
	int                    col_total [MAX_BW];
	int                    pos_in_row = 0;
	int                    rows_done = 0;

	axis_res_t pending_axes [$];
	int        snd_idle_pct = 0;
	int        rcv_idle_pct = 0;
	int        hold_req = 0;
	int        pixels_sent = 0;
	int        axes_checked = 0;
	int        reg_writes = 0;
	int        mismatches = 0;

	plan_row_t plan [33] = '{
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b1, 1'b1, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd77, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd200, 1'b1, 1'b1, AXIS_NONE},
		'{ROW_CFG, REG_STEP_LIMIT, 32'd1, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_WIDTH, 32'd3, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd17, 1'b1, 1'b1, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_WIDTH, 32'd511, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_HEIGHT, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_STEP_LIMIT, 32'd1023, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b1, 1'b1, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_HEIGHT, 32'd511, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b1, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_WIDTH, 32'd1, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_STEP_LIMIT, 32'd2, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd128, 1'b1, 1'b1, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_WIDTH, 32'd4, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_BOX_HEIGHT, 32'd1, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_CFG, REG_STEP_LIMIT, 32'd4, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd10, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd20, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd30, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd40, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd255, 1'b0, 1'b0, AXIS_ZERO},
		'{ROW_PIX, REG_BOX_WIDTH, 32'd0, 8'd0, 1'b1, 1'b0, AXIS_ZERO}
	};

	function automatic int offset_span(input int w);
		int lim;
		lim = (cfg_step > MAX_STEP) ? MAX_STEP : int'(cfg_step);
		lim = (lim == 0) ? 0 : lim - 1;
		if (w > 0 && lim > w - 1)
			lim = w - 1;
		return lim;
	endfunction

	function automatic int busy_cycles();
		int w;
		w = (cfg_width > MAX_BW) ? MAX_BW : int'(cfg_width);
		return w * (offset_span(w) + 2) + MAX_BW + 16;
	endfunction

	function automatic void open_box();
		foreach (col_total[i])
			col_total[i] = 0;
		pos_in_row = 0;
		rows_done = 0;
	endfunction

	function automatic bit predict_axis(input logic [PIX_W-1:0] pv, input logic lp,
		output axis_res_t r);
		int w, filled, lim, x, d, s, a, b, lo, hi, best;
		w = (cfg_width > MAX_BW) ? MAX_BW : int'(cfg_width);
		r = '0;
		if (w == 0) begin
			if (!lp)
				return 1'b0;
			open_box();
			r.nf = 1'b1;
			return 1'b1;
		end
		if (pos_in_row < MAX_BW)
			line_pix[pos_in_row] = pv;
		if (pos_in_row + 1 >= w || lp) begin
			filled = (pos_in_row + 1 > w) ? w : pos_in_row + 1;
			if (rows_done < cfg_height) begin
				lim = offset_span(w);
				for (x = 0; x < w; x++) begin
					s = col_total[x];
					for (d = 1; d <= lim; d++) begin
						lo = x - d;
						hi = x + d;
						a = (lo >= 0 && lo < filled) ? int'(line_pix[lo]) : 0;
						b = (hi < filled) ? int'(line_pix[hi]) : 0;
						s += (a > b) ? a - b : b - a;
					end
					col_total[x] = (s > SUM_CAP) ? SUM_CAP : s;
				end
			end
			pos_in_row = 0;
			if (rows_done < RC_CAP)
				rows_done++;
		end else begin
			pos_in_row++;
		end
		if (!lp)
			return 1'b0;
		best = 0;
		for (x = 1; x < w; x++)
			if (col_total[x] < col_total[best])
				best = x;
		r.axis  = best[AXIS_W-1:0];
		r.score = col_total[best][SUM_W-1:0];
		open_box();
		return 1'b1;
	endfunction

	task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wd,
		output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wd;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_xfer(1'b0, idx, 32'd0, rd);
		if (rd !== want) begin
			$display("%0t: register %0d read expected %0d got %0d", $time, idx, want, rd);
			mismatches++;
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_xfer(1'b1, idx, val, rd);
		case (idx)
			REG_BOX_WIDTH:  cfg_width  = val[BOX_W_BITS-1:0];
			REG_BOX_HEIGHT: cfg_height = val[BOX_H_BITS-1:0];
			REG_STEP_LIMIT: cfg_step   = val[STEP_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
		reg_check(idx, val);
	endtask

	// drop valid, wait for every result, then let in-flight rows finish
	task automatic settle();
		int n;
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (pending_axes.size() != 0)
			@(posedge clk);
		n = busy_cycles();
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pv, input logic lp, input bit typed,
		input axis_res_t preset);
		axis_res_t r;
		bit got;
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel_value <= pv;
		pix_ch.last_pixel  <= lp;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
		got = predict_axis(pv, lp, r);
		if (typed)
			r = preset;
		if (got)
			pending_axes = {pending_axes, r};
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		axis_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_axes.size() == 0) begin
				$display("%0t: result with nothing expected: axis %0d score %0d not_found %0b",
					$time, res_ch.axis_column, res_ch.best_score, res_ch.not_found);
				mismatches++;
			end else begin
				want = pending_axes.pop_front();
				axes_checked++;
				if (res_ch.axis_column !== want.axis) begin
					$display("%0t: axis_column expected %0d got %0d", $time, want.axis,
						res_ch.axis_column);
					mismatches++;
				end
				if (res_ch.best_score !== want.score) begin
					$display("%0t: best_score expected %0d got %0d", $time, want.score,
						res_ch.best_score);
					mismatches++;
				end
				if (res_ch.not_found !== want.nf) begin
					$display("%0t: not_found expected %0b got %0b", $time, want.nf,
						res_ch.not_found);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int          ph, w_eff, rows, total, k, col, ctr, style, sel, phase_start;
		logic [31:0] wv, hv, sv;
		logic [7:0]  shade [16];
		logic [7:0]  pv;
		box_kind_t   kind;

		pix_ch.valid       = 1'b0;
		pix_ch.pixel_value = '0;
		pix_ch.last_pixel  = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		open_box();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 34;
		rcv_idle_pct = 68;
		reg_check(REG_BOX_WIDTH, 32'(BOX_WIDTH_RST));
		reg_check(REG_BOX_HEIGHT, 32'(BOX_HEIGHT_RST));
		reg_check(REG_STEP_LIMIT, 32'(STEP_LIMIT_RST));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				send_pixel(plan[i].pv, plan[i].lp, plan[i].typed, plan[i].exp);
			end
		end

		for (ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					snd_idle_pct = 34;
					rcv_idle_pct = 68;
				end
				1: begin
					snd_idle_pct = 68;
					rcv_idle_pct = 34;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			sel = $urandom_range(0, 7);
			if (ph == 4 || sel > 1)
				wv = $urandom_range(1, 12);
			else if (sel == 0)
				wv = 0;
			else
				wv = $urandom_range(256, 511);
			sel = $urandom_range(0, 7);
			hv = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(5, 511) : $urandom_range(1, 4);
			if (wv > 16)
				sv = $urandom_range(0, 6);
			else if ($urandom_range(0, 1) == 1)
				sv = $urandom_range(0, 1023);
			else
				sv = $urandom_range(0, 14);
			settle();
			reg_write(REG_BOX_WIDTH, wv);
			reg_write(REG_BOX_HEIGHT, hv);
			reg_write(REG_STEP_LIMIT, sv);
			// hold results back so the block fills and stalls its input
			if (ph == 4)
				hold_req = 4000;
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < 225) begin
				w_eff = (wv > MAX_BW) ? MAX_BW : int'(wv);
				style = $urandom_range(0, 3);
				ctr   = (w_eff == 0) ? 0 : $urandom_range(0, w_eff - 1);
				foreach (shade[i])
					shade[i] = $urandom_range(0, 255);
				if (w_eff == 0) begin
					total = $urandom_range(1, 5);
				end else if (w_eff > 16) begin
					total = $urandom_range(1, 24);
				end else begin
					rows = (hv >= 1 && hv <= 6) ? int'(hv) : $urandom_range(1, 4);
					k = $urandom_range(0, 9);
					kind = (k < 7) ? BOX_WHOLE : (k < 9) ? BOX_SHORT_TAIL : BOX_EXTRA_ROWS;
					case (kind)
						BOX_WHOLE:      total = rows * w_eff;
						BOX_SHORT_TAIL: total = (rows - 1) * w_eff + $urandom_range(1, w_eff);
						default:        total = (rows + $urandom_range(1, 2)) * w_eff;
					endcase
				end
				for (k = 0; k < total; k++) begin
					col = (w_eff == 0) ? k : k % w_eff;
					case (style)
						0:       pv = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
						1:       pv = shade[((col > ctr) ? col - ctr : ctr - col) % 16];
						default: pv = $urandom_range(0, 255);
					endcase
					send_pixel(pv, k == total - 1, 1'b0, AXIS_ZERO);
				end
			end
		end

		settle();
		$display("Run covered %0d pixel items and %0d axis results over %0d register writes,",
			pixels_sent, axes_checked, reg_writes);
		$display("with stalls on both channels and a long hold-off on the result side.");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("Timed out with %0d results outstanding", pending_axes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
